// ===== hdl/skts_pkg.sv =====
`default_nettype none

package skts_pkg;

	// Default number of table slots
	localparam int unsigned SKTS_DEPTH = 256;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned SLOT_W   = 8;
	localparam int unsigned COUNT_W  = 9;
	localparam int unsigned STATUS_W = 2;

	// Operation codes carried on s_tuser
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_FIND  = 1'b1;

	// Result codes carried on m_tuser
	localparam logic [STATUS_W-1:0] STAT_WRITTEN = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FOUND   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BADKEY  = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/sorted_key_table_search_top.sv =====
// Channel   Direction  Signals                       Payload
// s_        in         s_tvalid s_tready s_tdata     s_tdata: slot[7:0], key[39:8]
//                      s_tuser                       s_tuser: func
// m_        out        m_tvalid m_tready m_tdata     m_tdata: match_slot[7:0]
//                      m_tuser                       m_tuser: status[1:0]
// cfg_      in         cfg_valid cfg_ready cfg_data  cfg_data: entry_count[8:0]
//
// A write, a rejected key or a search of an empty table moves from its transfer
// straight to the final state. A search makes p probes, p at most ceil(log2(n + 1))
// with n the entry count saturated to the table depth: 9 probes for 256 slots.
// s_tready returns when the final state loads the result register.
// One key memory read per cycle sets one probe per cycle; the memory has no reset.
// A finished item stalls in the final state until the output register is free.
`default_nettype none

module sorted_key_table_search_top
	import skts_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = SKTS_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [39:0]           s_tdata,   // slot[7:0], key[39:8]
	input  wire logic                  s_tuser,   // func[0]
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [7:0]            m_tdata,   // match_slot[7:0]
	output      logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [COUNT_W-1:0]    cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = AW + 1;
	localparam int unsigned NW = (CW > COUNT_W) ? CW : COUNT_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]            state_q;
	logic [COUNT_W-1:0]    entry_count_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         hx_q;   // exclusive upper bound of the search range
	logic [CW-1:0]         mid_q;
	logic [STATUS_W-1:0]   pend_status_q;
	logic [SLOT_W-1:0]     pend_slot_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [SLOT_W-1:0]     out_slot_q;

	logic [KEY_W-1:0]      mem [TABLE_DEPTH];
	logic [KEY_W-1:0]      rd_data_q;

	logic                  in_xfer;
	logic                  out_free;
	logic [SLOT_W-1:0]     in_slot;
	logic signed [KEY_W-1:0] in_key;
	logic                  wr_en;
	logic [CW-1:0]         n_sat;
	logic [CW-1:0]         mid0;
	logic signed [KEY_W-1:0] probe;
	logic                  hit;
	logic [CW-1:0]         lo_n;
	logic [CW-1:0]         hx_n;
	logic [CW-1:0]         mid_n;
	logic [AW-1:0]         rd_addr;

	assign in_slot   = s_tdata[SLOT_W-1:0];
	assign in_key    = signed'(s_tdata[SLOT_W +: KEY_W]);
	assign s_tready  = (state_q == S_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_slot_q;
	assign m_tuser  = out_status_q;

	assign wr_en = in_xfer && (s_tuser == FUNC_WRITE)
		&& (32'(in_slot) < 32'(TABLE_DEPTH));

	// Saturate the slot count to the table depth
	always_comb begin
		if (NW'(entry_count_q) > NW'(TABLE_DEPTH))
			n_sat = CW'(TABLE_DEPTH);
		else
			n_sat = CW'(entry_count_q);
	end

	assign mid0 = (n_sat - CW'(1)) >> 1;

	// One bisection step on the probe returned for mid_q
	always_comb begin
		probe = signed'(rd_data_q);
		hit   = (probe == key_q);
		if (probe < key_q) begin
			lo_n = mid_q + CW'(1);
			hx_n = hx_q;
		end else begin
			lo_n = lo_q;
			hx_n = mid_q;
		end
		mid_n = lo_n + ((hx_n - CW'(1) - lo_n) >> 1);
	end

	assign rd_addr = (state_q == S_IDLE) ? mid0[AW-1:0] : mid_n[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[AW'(in_slot)] <= s_tdata[SLOT_W +: KEY_W];
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			key_q <= in_key;
		unique case (state_q)
			S_IDLE: begin
				lo_q  <= '0;
				hx_q  <= n_sat;
				mid_q <= mid0;
			end
			S_SEARCH: begin
				lo_q  <= lo_n;
				hx_q  <= hx_n;
				mid_q <= mid_n;
			end
			default: begin
				mid_q <= mid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			pend_status_q <= STAT_WRITTEN;
			pend_slot_q   <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= STAT_WRITTEN;
			out_slot_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				entry_count_q <= cfg_data;

			// Load a finished result, else drop the one just transferred
			if ((state_q == S_FINISH) && out_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= pend_status_q;
				out_slot_q   <= pend_slot_q;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						pend_slot_q <= '0;
						if (s_tuser == FUNC_WRITE) begin
							pend_status_q <= STAT_WRITTEN;
							state_q       <= S_FINISH;
						end else if (in_key <= 0) begin
							pend_status_q <= STAT_BADKEY;
							state_q       <= S_FINISH;
						end else if (n_sat == '0) begin
							pend_status_q <= STAT_MISSING;
							state_q       <= S_FINISH;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						pend_status_q <= STAT_FOUND;
						pend_slot_q   <= SLOT_W'(mid_q);
						state_q       <= S_FINISH;
					end else if (lo_n >= hx_n) begin
						pend_status_q <= STAT_MISSING;
						state_q       <= S_FINISH;
					end
				end
				S_FINISH: begin
					// Hold until the output register is free
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/skts_checker.sv =====
`default_nettype none

module skts_checker
	import skts_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [7:0]          m_tdata,
	input wire logic [STATUS_W-1:0] m_tuser
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only a found result carries a slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_FOUND) |-> (m_tdata == 8'd0))
		else $error("slot set on a result other than found");

	// One item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// A write taken while the output is free reports a written result
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == FUNC_WRITE) && !m_tvalid
		|=> ##1 (m_tvalid && (m_tuser == STAT_WRITTEN)))
		else $error("write result missing");

endmodule

bind sorted_key_table_search_top skts_checker u_skts_checker (.*);

`default_nettype wire
